// ===== hdl/cip_pkg.sv =====
package cip_pkg;

	localparam int MAG_W  = 62;
	localparam int WIDE_W = MAG_W + 1;
	localparam int HALF_W = MAG_W / 2;
	localparam int PART_W = 2 * HALF_W;
	localparam int SUM_W  = 2 * MAG_W + 1;

	localparam logic [MAG_W-1:0] WIDE_LIM = '1;
	localparam logic signed [WIDE_W:0] WIDE_LIM_S = {2'b00, WIDE_LIM};
	localparam int ZERO_VAL = 500;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef struct packed {
		logic [PART_W-1:0] hh;
		logic [PART_W-1:0] hl;
		logic [PART_W-1:0] lh;
		logic [PART_W-1:0] ll;
	} parts_t;

	typedef struct packed {
		logic  sat;
		wide_t wr;
		wide_t wi;
		wide_t zr;
		wide_t zi;
	} cip_item_t;

	typedef enum logic {
		REG_EXPONENT = 1'b0,
		REG_INVERT   = 1'b1
	} cip_reg_t;

	function automatic mag_t mag(input wide_t v);
		wide_t n;
		n = -v;
		return v[WIDE_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	function automatic parts_t split_mul(input mag_t a, input mag_t b);
		parts_t p;
		p.hh = PART_W'(a[MAG_W-1:HALF_W]) * PART_W'(b[MAG_W-1:HALF_W]);
		p.hl = PART_W'(a[MAG_W-1:HALF_W]) * PART_W'(b[HALF_W-1:0]);
		p.lh = PART_W'(a[HALF_W-1:0]) * PART_W'(b[MAG_W-1:HALF_W]);
		p.ll = PART_W'(a[HALF_W-1:0]) * PART_W'(b[HALF_W-1:0]);
		return p;
	endfunction

	function automatic logic [SUM_W-1:0] join_parts(input parts_t p);
		logic [SUM_W-1:0] mid;
		mid = SUM_W'(p.hl) + SUM_W'(p.lh);
		return (SUM_W'(p.hh) << (2 * HALF_W)) + (mid << HALF_W) + SUM_W'(p.ll);
	endfunction

endpackage

// ===== hdl/cip_cmul.sv =====
module cip_cmul #(
	parameter int FRAC_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                active,
	input  logic                in_valid,
	input  cip_pkg::cip_item_t  in_item,
	output logic                out_valid,
	output cip_pkg::cip_item_t  out_item
);
	import cip_pkg::*;

	localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);

	logic      valid_s1, valid_s2, valid_s3;
	cip_item_t item_s1, item_s2, item_s3;
	parts_t    parts_s1 [4];
	logic      neg_s1 [4];
	wide_t     prod_s2 [4];

	mag_t             ma [4];
	mag_t             mb [4];
	logic             ng [4];
	logic [SUM_W-1:0] tsum [4];
	logic [SUM_W-1:0] tsh [4];
	mag_t             mv [4];
	logic             clp [4];
	wide_t            prod_c [4];
	cip_item_t        item_c2, item_c3;
	logic signed [WIDE_W:0] re_sum, im_sum;
	wide_t            re_cl, im_cl;
	logic             re_sat, im_sat;

	always_comb begin
		ma[0] = mag(in_item.wr);
		mb[0] = mag(in_item.zr);
		ng[0] = in_item.wr[WIDE_W-1] ^ in_item.zr[WIDE_W-1];
		ma[1] = mag(in_item.wi);
		mb[1] = mag(in_item.zi);
		ng[1] = in_item.wi[WIDE_W-1] ^ in_item.zi[WIDE_W-1];
		ma[2] = mag(in_item.wr);
		mb[2] = mag(in_item.zi);
		ng[2] = in_item.wr[WIDE_W-1] ^ in_item.zi[WIDE_W-1];
		ma[3] = mag(in_item.wi);
		mb[3] = mag(in_item.zr);
		ng[3] = in_item.wi[WIDE_W-1] ^ in_item.zr[WIDE_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			for (int j = 0; j < 4; j++) begin
				parts_s1[j] <= split_mul(ma[j], mb[j]);
				neg_s1[j]   <= ng[j];
			end
		end
	end

	always_comb begin
		item_c2 = item_s1;
		for (int j = 0; j < 4; j++) begin
			tsum[j] = join_parts(parts_s1[j]) + RND;
			tsh[j]  = tsum[j] >> FRAC_BITS;
			clp[j]  = |tsh[j][SUM_W-1:MAG_W];
			mv[j]   = clp[j] ? WIDE_LIM : tsh[j][MAG_W-1:0];
			prod_c[j] = neg_s1[j] ? -wide_t'({1'b0, mv[j]}) : wide_t'({1'b0, mv[j]});
		end
		item_c2.sat = item_s1.sat | (active & (clp[0] | clp[1] | clp[2] | clp[3]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_c2;
			for (int j = 0; j < 4; j++) begin
				prod_s2[j] <= prod_c[j];
			end
		end
	end

	always_comb begin
		re_sum = (WIDE_W + 1)'(prod_s2[0]) - (WIDE_W + 1)'(prod_s2[1]);
		im_sum = (WIDE_W + 1)'(prod_s2[2]) + (WIDE_W + 1)'(prod_s2[3]);
		re_sat = (re_sum > WIDE_LIM_S) || (re_sum < -WIDE_LIM_S);
		im_sat = (im_sum > WIDE_LIM_S) || (im_sum < -WIDE_LIM_S);
		if (re_sum > WIDE_LIM_S) begin
			re_cl = wide_t'(WIDE_LIM_S);
		end else if (re_sum < -WIDE_LIM_S) begin
			re_cl = -wide_t'(WIDE_LIM_S);
		end else begin
			re_cl = re_sum[WIDE_W-1:0];
		end
		if (im_sum > WIDE_LIM_S) begin
			im_cl = wide_t'(WIDE_LIM_S);
		end else if (im_sum < -WIDE_LIM_S) begin
			im_cl = -wide_t'(WIDE_LIM_S);
		end else begin
			im_cl = im_sum[WIDE_W-1:0];
		end
		item_c3 = item_s2;
		if (active) begin
			item_c3.wr  = re_cl;
			item_c3.wi  = im_cl;
			item_c3.sat = item_s2.sat | re_sat | im_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= item_c3;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

// ===== hdl/complex_integer_power_core.sv =====
// Raises one complex number per transaction to the power n (2 to 6) in signed
// fixed point, or returns its reciprocal power when invert is set.
// The input stream carries z_re in the low half of s_axis_tdata and z_im above it.
// The output stream carries w_re and w_im in m_axis_tdata the same way, with
// zero_divisor in m_axis_tuser bit 0 and saturated in bit 1.
// The APB port holds exponent at address 0 and invert at address 4; write them
// only while no transaction is in flight.
// From input acceptance to output valid the pipeline holds an input stage that
// loads at the accepting edge, five three-stage complex multipliers, three
// stages for the squared magnitude, one stage per quotient bit of the two
// restoring dividers (63 + FRAC_BITS stages) and two output stages.
// One transaction is accepted every cycle while the skid register is empty.
// Reset clears every valid bit and loads exponent 2 and invert 0.
// When the receiver stalls, one more result is caught in a skid register and
// the whole pipeline then holds until it drains; nothing is lost or repeated.
module complex_integer_power_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// z_re, z_im
	input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// w_re, w_im
	output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// zero_divisor, saturated
	output logic [1:0] m_axis_tuser,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cip_pkg::*;

	localparam int TD_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int NMUL  = 5;
	localparam int MD_W  = SUM_W + 1 - FRAC_BITS;
	localparam int QW    = MAG_W + 1 + FRAC_BITS;
	localparam int NW    = ((MAG_W + FRAC_BITS) > (MD_W - 1) ?
		(MAG_W + FRAC_BITS) : (MD_W - 1)) + 1;
	localparam logic [2:0] EXP_LO  = 3'd3;
	localparam logic [2:0] EXP_HI  = 3'd6;
	localparam logic [2:0] EXP_DEF = 3'd2;
	localparam logic [SUM_W:0] RND = (SUM_W + 1)'(1) << (FRAC_BITS - 1);
	localparam wide_t ZERO_PART = wide_t'(64'(ZERO_VAL) << FRAC_BITS);
	localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

	logic [2:0] exp_q;
	logic       inv_q;
	logic [2:0] n_eff;
	logic       en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= EXP_DEF;
			inv_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (cip_reg_t'(paddr[2]))
				REG_EXPONENT: exp_q <= pwdata[2:0];
				REG_INVERT:   inv_q <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (cip_reg_t'(paddr[2]))
			REG_EXPONENT: prdata = {29'b0, exp_q};
			REG_INVERT:   prdata = {31'b0, inv_q};
			default:      prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign n_eff  = (exp_q < EXP_LO || exp_q > EXP_HI) ? EXP_DEF : exp_q;

	// Input stage.
	logic signed [DATA_WIDTH-1:0] zre_in, zim_in;
	logic signed [63:0] zre_x, zim_x;
	cip_item_t item_c1;
	logic      in_v_s1;
	cip_item_t in_item_s1;

	assign zre_in = s_axis_tdata[DATA_WIDTH-1:0];
	assign zim_in = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign zre_x  = 64'(zre_in);
	assign zim_x  = 64'(zim_in);

	always_comb begin
		item_c1.sat = (zre_x > WIDE_LIM_S) || (zre_x < -WIDE_LIM_S) ||
			(zim_x > WIDE_LIM_S) || (zim_x < -WIDE_LIM_S);
		if (zre_x > WIDE_LIM_S) begin
			item_c1.zr = wide_t'(WIDE_LIM_S);
		end else if (zre_x < -WIDE_LIM_S) begin
			item_c1.zr = -wide_t'(WIDE_LIM_S);
		end else begin
			item_c1.zr = zre_x[WIDE_W-1:0];
		end
		if (zim_x > WIDE_LIM_S) begin
			item_c1.zi = wide_t'(WIDE_LIM_S);
		end else if (zim_x < -WIDE_LIM_S) begin
			item_c1.zi = -wide_t'(WIDE_LIM_S);
		end else begin
			item_c1.zi = zim_x[WIDE_W-1:0];
		end
		item_c1.wr = item_c1.zr;
		item_c1.wi = item_c1.zi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (en) begin
			in_v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_item_s1 <= item_c1;
		end
	end

	// Power chain.
	logic      mv [NMUL+1];
	cip_item_t mi [NMUL+1];

	assign mv[0] = in_v_s1;
	assign mi[0] = in_item_s1;

	for (genvar k = 0; k < NMUL; k++) begin : g_mul
		logic act;
		assign act = (3'(k + 1) < n_eff);
		cip_cmul #(.FRAC_BITS(FRAC_BITS)) u_cmul (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.active   (act),
			.in_valid (mv[k]),
			.in_item  (mi[k]),
			.out_valid(mv[k+1]),
			.out_item (mi[k+1])
		);
	end

	// Squared magnitude.
	logic   sq_v_s17, sq_v_s18, pr_v_s19;
	parts_t sq_rr_s17, sq_ii_s17;
	wide_t  sq_wr_s17, sq_wi_s17, sq_wr_s18, sq_wi_s18, pr_wr_s19, pr_wi_s19;
	logic   sq_sat_s17, sq_sat_s18, pr_sat_s19;
	logic [MD_W-1:0] sq_m_s18, pr_d_s19;
	logic            sq_zd_s18, pr_zd_s19;
	logic [NW-1:0]   pr_nre_s19, pr_nim_s19;
	logic [SUM_W:0]  msum;

	assign msum = (SUM_W + 1)'(join_parts(sq_rr_s17)) +
		(SUM_W + 1)'(join_parts(sq_ii_s17)) + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s17 <= 1'b0;
			sq_v_s18 <= 1'b0;
			pr_v_s19 <= 1'b0;
		end else if (en) begin
			sq_v_s17 <= mv[NMUL];
			sq_v_s18 <= sq_v_s17;
			pr_v_s19 <= sq_v_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rr_s17  <= split_mul(mag(mi[NMUL].wr), mag(mi[NMUL].wr));
			sq_ii_s17  <= split_mul(mag(mi[NMUL].wi), mag(mi[NMUL].wi));
			sq_wr_s17  <= mi[NMUL].wr;
			sq_wi_s17  <= mi[NMUL].wi;
			sq_sat_s17 <= mi[NMUL].sat;
			sq_m_s18   <= MD_W'(msum >> FRAC_BITS);
			sq_zd_s18  <= (msum >> FRAC_BITS) == '0;
			sq_wr_s18  <= sq_wr_s17;
			sq_wi_s18  <= sq_wi_s17;
			sq_sat_s18 <= sq_sat_s17;
			pr_nre_s19 <= (NW'(mag(sq_wr_s18)) << FRAC_BITS) + NW'(sq_m_s18 >> 1);
			pr_nim_s19 <= (NW'(mag(sq_wi_s18)) << FRAC_BITS) + NW'(sq_m_s18 >> 1);
			pr_d_s19   <= sq_m_s18;
			pr_zd_s19  <= sq_zd_s18;
			pr_wr_s19  <= sq_wr_s18;
			pr_wi_s19  <= sq_wi_s18;
			pr_sat_s19 <= sq_sat_s18;
		end
	end

	// Restoring dividers, one quotient bit per stage.
	logic            div_v_s   [QW];
	logic [MD_W-1:0] div_rre_s [QW];
	logic [MD_W-1:0] div_rim_s [QW];
	logic [QW-1:0]   div_qre_s [QW];
	logic [QW-1:0]   div_qim_s [QW];
	logic [NW-1:0]   div_nre_s [QW];
	logic [NW-1:0]   div_nim_s [QW];
	logic [MD_W-1:0] div_d_s   [QW];
	wide_t           div_wr_s  [QW];
	wide_t           div_wi_s  [QW];
	logic            div_sat_s [QW];
	logic            div_zd_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic            v_in, sat_in, zd_in, gre, gim;
		logic [MD_W-1:0] rre_in, rim_in, d_in;
		logic [QW-1:0]   qre_in, qim_in;
		logic [NW-1:0]   nre_in, nim_in;
		wide_t           wr_in, wi_in;
		logic [MD_W:0]   tre, tim;

		if (k == 0) begin : g_first
			assign v_in   = pr_v_s19;
			assign rre_in = MD_W'(pr_nre_s19 >> QW);
			assign rim_in = MD_W'(pr_nim_s19 >> QW);
			assign qre_in = '0;
			assign qim_in = '0;
			assign nre_in = pr_nre_s19;
			assign nim_in = pr_nim_s19;
			assign d_in   = pr_d_s19;
			assign wr_in  = pr_wr_s19;
			assign wi_in  = pr_wi_s19;
			assign sat_in = pr_sat_s19;
			assign zd_in  = pr_zd_s19;
		end else begin : g_next
			assign v_in   = div_v_s[k-1];
			assign rre_in = div_rre_s[k-1];
			assign rim_in = div_rim_s[k-1];
			assign qre_in = div_qre_s[k-1];
			assign qim_in = div_qim_s[k-1];
			assign nre_in = div_nre_s[k-1];
			assign nim_in = div_nim_s[k-1];
			assign d_in   = div_d_s[k-1];
			assign wr_in  = div_wr_s[k-1];
			assign wi_in  = div_wi_s[k-1];
			assign sat_in = div_sat_s[k-1];
			assign zd_in  = div_zd_s[k-1];
		end

		assign tre = {rre_in, nre_in[QW-1-k]};
		assign tim = {rim_in, nim_in[QW-1-k]};
		assign gre = tre >= {1'b0, d_in};
		assign gim = tim >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (en) begin
				div_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rre_s[k] <= gre ? MD_W'(tre - {1'b0, d_in}) : tre[MD_W-1:0];
				div_rim_s[k] <= gim ? MD_W'(tim - {1'b0, d_in}) : tim[MD_W-1:0];
				div_qre_s[k] <= {qre_in[QW-2:0], gre};
				div_qim_s[k] <= {qim_in[QW-2:0], gim};
				div_nre_s[k] <= nre_in;
				div_nim_s[k] <= nim_in;
				div_d_s[k]   <= d_in;
				div_wr_s[k]  <= wr_in;
				div_wi_s[k]  <= wi_in;
				div_sat_s[k] <= sat_in;
				div_zd_s[k]  <= zd_in;
			end
		end
	end

	// Sign, substitution and output clipping.
	logic                  fin_v_sn, fin_zd_sn, fin_sat_sn;
	logic [DATA_WIDTH-1:0] fin_re_sn, fin_im_sn;
	logic                  qre_clp, qim_clp, neg_re, neg_im, zd_c, sat_c;
	mag_t                  qre_m, qim_m;
	wide_t                 rre_c, rim_c, fre_c, fim_c;
	logic signed [63:0]    vre, vim, cre, cim;

	always_comb begin
		qre_clp = |div_qre_s[QW-1][QW-1:MAG_W];
		qim_clp = |div_qim_s[QW-1][QW-1:MAG_W];
		qre_m   = qre_clp ? WIDE_LIM : div_qre_s[QW-1][MAG_W-1:0];
		qim_m   = qim_clp ? WIDE_LIM : div_qim_s[QW-1][MAG_W-1:0];
		neg_re  = div_wr_s[QW-1][WIDE_W-1];
		neg_im  = !div_wi_s[QW-1][WIDE_W-1] && (div_wi_s[QW-1] != '0);
		rre_c   = neg_re ? -wide_t'({1'b0, qre_m}) : wide_t'({1'b0, qre_m});
		rim_c   = neg_im ? -wide_t'({1'b0, qim_m}) : wide_t'({1'b0, qim_m});
		zd_c    = 1'b0;
		sat_c   = div_sat_s[QW-1];
		fre_c   = div_wr_s[QW-1];
		fim_c   = div_wi_s[QW-1];
		if (inv_q) begin
			if (div_zd_s[QW-1]) begin
				zd_c  = 1'b1;
				fre_c = ZERO_PART;
				fim_c = ZERO_PART;
			end else begin
				fre_c = rre_c;
				fim_c = rim_c;
				sat_c = sat_c | qre_clp | qim_clp;
			end
		end
		vre = 64'(fre_c);
		vim = 64'(fim_c);
		cre = (vre > OUT_HI) ? OUT_HI : ((vre < OUT_LO) ? OUT_LO : vre);
		cim = (vim > OUT_HI) ? OUT_HI : ((vim < OUT_LO) ? OUT_LO : vim);
		sat_c = sat_c | (vre > OUT_HI) | (vre < OUT_LO) | (vim > OUT_HI) | (vim < OUT_LO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_sn <= 1'b0;
		end else if (en) begin
			fin_v_sn <= div_v_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_re_sn  <= cre[DATA_WIDTH-1:0];
			fin_im_sn  <= cim[DATA_WIDTH-1:0];
			fin_zd_sn  <= zd_c;
			fin_sat_sn <= sat_c;
		end
	end

	// Output register with skid.
	logic                  out_v_q, skid_v_q, push;
	logic [DATA_WIDTH-1:0] out_re_q, out_im_q, skid_re_q, skid_im_q;
	logic [1:0]            out_user_q, skid_user_q;

	assign en   = !skid_v_q;
	assign push = en && fin_v_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_axis_tready || !out_v_q) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_re_q   <= skid_re_q;
				out_im_q   <= skid_im_q;
				out_user_q <= skid_user_q;
			end else begin
				out_re_q   <= fin_re_sn;
				out_im_q   <= fin_im_sn;
				out_user_q <= {fin_sat_sn, fin_zd_sn};
			end
		end else if (push) begin
			skid_re_q   <= fin_re_sn;
			skid_im_q   <= fin_im_sn;
			skid_user_q <= {fin_sat_sn, fin_zd_sn};
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = TD_W'({out_im_q, out_re_q});
	assign m_axis_tuser  = out_user_q;

endmodule

// ===== hdl/cip_chk.sv =====
module cip_chk #(
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	input logic pready
);
	import cip_pkg::*;

	logic inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			cip_reg_t'(paddr[2]) == REG_INVERT) begin
			inv_q <= pwdata[0];
		end
	end

	a_zero_equal_parts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		m_axis_tdata[DATA_WIDTH-1:0] == m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])
		else $error("zero divisor result with unequal parts");

	a_zero_needs_invert: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> inv_q)
		else $error("zero divisor flag outside inverse mode");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output transaction changed");

	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no output transaction waiting");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind complex_integer_power_core cip_chk #(.DATA_WIDTH(DATA_WIDTH)) u_cip_chk (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int DW = 32;
	localparam int FB = 20;
	localparam logic [127:0] WIDE_MAX = (128'd1 << 62) - 1;
	localparam int DRAIN_CYCLES = 150;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct {
		logic [DW-1:0] w_re;
		logic [DW-1:0] w_im;
		logic zero_div;
		logic sat;
	} power_result_t;

	typedef struct {
		logic [2:0] exponent;
		logic invert;
		logic [DW-1:0] z_re;
		logic [DW-1:0] z_im;
		bit typed;
		power_result_t want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// z_re, z_im
	logic [63:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// w_re, w_im
	logic [63:0] m_axis_tdata;
	// zero_divisor, saturated
	logic [1:0] m_axis_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	power_result_t pending_powers[$];
	logic [2:0] cur_exponent;
	logic cur_invert;
	int errors;
	bit idle_on;
	bit long_hold;

	complex_integer_power_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic logic [63:0] magnitude_of(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_wide(input logic [127:0] m, input bit neg, inout bit sat);
		logic [127:0] c;
		c = m;
		if (c > WIDE_MAX) begin
			c = WIDE_MAX;
			sat = 1;
		end
		return neg ? -longint'(c[63:0]) : longint'(c[63:0]);
	endfunction

	function automatic longint fixed_product(input longint a, input longint b, inout bit sat);
		logic [127:0] p;
		p = {64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)};
		p = p + (128'd1 << (FB - 1));
		p = p >> FB;
		return signed_wide(p, (a < 0) != (b < 0), sat);
	endfunction

	function automatic longint clip_wide_int(input longint v, inout bit sat);
		if (v > longint'(WIDE_MAX)) begin
			sat = 1;
			return longint'(WIDE_MAX);
		end
		if (v < -longint'(WIDE_MAX)) begin
			sat = 1;
			return -longint'(WIDE_MAX);
		end
		return v;
	endfunction

	function automatic longint reciprocal_part(input longint part, input bit neg,
			input logic [127:0] m, inout bit sat);
		logic [127:0] num;
		num = ({64'd0, magnitude_of(part)} << FB) + (m >> 1);
		return signed_wide(num / m, neg, sat);
	endfunction

	function automatic logic [DW-1:0] clip_out(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return 32'h80000000;
		end
		return v[DW-1:0];
	endfunction

	function automatic power_result_t predict_power(input logic [DW-1:0] re, input logic [DW-1:0] im,
			input logic [2:0] exponent, input logic invert);
		power_result_t res;
		bit sat;
		longint zr, zi, wr, wi, tr, ti, rr, ri;
		int n;
		logic [127:0] m;
		sat = 0;
		res.zero_div = 0;
		zr = longint'($signed(re));
		zi = longint'($signed(im));
		wr = zr;
		wi = zi;
		n = (exponent < 3 || exponent > 6) ? 2 : int'(exponent);
		for (int k = 1; k < n; k++) begin
			tr = fixed_product(wr, zr, sat) - fixed_product(wi, zi, sat);
			ti = fixed_product(wr, zi, sat) + fixed_product(wi, zr, sat);
			wr = clip_wide_int(tr, sat);
			wi = clip_wide_int(ti, sat);
		end
		if (invert) begin
			m = {64'd0, magnitude_of(wr)} * {64'd0, magnitude_of(wr)}
				+ {64'd0, magnitude_of(wi)} * {64'd0, magnitude_of(wi)};
			m = (m + (128'd1 << (FB - 1))) >> FB;
			if (m == 0) begin
				res.zero_div = 1;
				wr = longint'(500) <<< FB;
				wi = wr;
			end else begin
				rr = reciprocal_part(wr, wr < 0, m, sat);
				ri = reciprocal_part(wi, wi > 0, m, sat);
				wr = rr;
				wi = ri;
			end
		end
		res.w_re = clip_out(wr, sat);
		res.w_im = clip_out(wi, sat);
		res.sat = sat;
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic wait_idle();
		while (pending_powers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input cip_pkg::cip_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == cip_pkg::REG_EXPONENT) cur_exponent = value[2:0];
		else cur_invert = value[0];
	endtask

	task automatic set_mode(input logic [2:0] exponent, input logic invert);
		wait_idle();
		write_register(cip_pkg::REG_EXPONENT, 32'(exponent));
		write_register(cip_pkg::REG_INVERT, 32'(invert));
	endtask

	// Called at a falling edge with tvalid either low or still high from the last transaction.
	task automatic send_point(input logic [DW-1:0] re, input logic [DW-1:0] im,
			input bit typed, input power_result_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {im, re};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_powers.push_back(typed ? want : predict_power(re, im, cur_exponent, cur_invert));
		@(negedge clk);
	endtask

	function automatic logic [DW-1:0] random_part();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
			2: return 32'($signed($urandom_range(0, 32'h04000000)) - 32'sh02000000);
			default: return 32'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			int stall;
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 0;
			end
			stall = idle_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				m_axis_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			power_result_t want;
			if (pending_powers.size() == 0) begin
				$display("%t: unexpected transaction w_re=%h w_im=%h tuser=%b", $time,
					m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
				errors++;
			end else begin
				want = pending_powers.pop_front();
				if (m_axis_tdata[31:0] !== want.w_re) begin
					$display("%t: w_re expected %h actual %h", $time, want.w_re, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[63:32] !== want.w_im) begin
					$display("%t: w_im expected %h actual %h", $time, want.w_im, m_axis_tdata[63:32]);
					errors++;
				end
				if (m_axis_tuser[0] !== want.zero_div) begin
					$display("%t: zero_divisor expected %b actual %b", $time, want.zero_div,
						m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== want.sat) begin
					$display("%t: saturated expected %b actual %b", $time, want.sat, m_axis_tuser[1]);
					errors++;
				end
			end
		end
	end

	initial begin
		directed_row_t rows[14];
		power_result_t none;
		logic [2:0] modes_exp[12];
		logic modes_inv[12];
		none = '{default: 0};
		rows[0] = '{3'd2, 1'b0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 1'b0, 1'b0}};
		rows[1] = '{3'd2, 1'b0, 32'h00100000, 32'h0, 1, '{32'h00100000, 32'h0, 1'b0, 1'b0}};
		rows[2] = '{3'd2, 1'b0, 32'h80000000, 32'h80000000, 1,
			'{32'h0, 32'h7fffffff, 1'b0, 1'b1}};
		rows[3] = '{3'd2, 1'b0, 32'h7fffffff, 32'h7fffffff, 0, none};
		rows[4] = '{3'd2, 1'b0, 32'h80000000, 32'h7fffffff, 0, none};
		rows[5] = '{3'd3, 1'b0, 32'h00100000, 32'h00100000, 0, none};
		rows[6] = '{3'd4, 1'b0, 32'hfff80000, 32'h00180000, 0, none};
		rows[7] = '{3'd5, 1'b0, 32'h00123456, 32'hffedcba9, 0, none};
		rows[8] = '{3'd6, 1'b0, 32'h7fffffff, 32'h80000000, 0, none};
		rows[9] = '{3'd7, 1'b0, 32'h00300000, 32'h00100000, 0, none};
		rows[10] = '{3'd2, 1'b1, 32'h0, 32'h0, 1, '{32'h1f400000, 32'h1f400000, 1'b1, 1'b0}};
		rows[11] = '{3'd6, 1'b1, 32'h1, 32'h0, 1, '{32'h1f400000, 32'h1f400000, 1'b1, 1'b0}};
		rows[12] = '{3'd6, 1'b1, 32'h7fffffff, 32'h7fffffff, 0, none};
		rows[13] = '{3'd0, 1'b1, 32'h80000000, 32'h00080000, 0, none};
		modes_exp = '{3'd2, 3'd3, 3'd6, 3'd4, 3'd5, 3'd0, 3'd1, 3'd7, 3'd2, 3'd3, 3'd6, 3'd5};
		modes_inv = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

		errors = 0;
		idle_on = 1;
		long_hold = 0;
		cur_exponent = 3'd2;
		cur_invert = 1'b0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int i = 0; i < 14; i++) begin
			if (rows[i].exponent != cur_exponent || rows[i].invert != cur_invert) begin
				s_axis_tvalid <= 0;
				set_mode(rows[i].exponent, rows[i].invert);
			end
			send_point(rows[i].z_re, rows[i].z_im, rows[i].typed, rows[i].want);
		end

		for (int p = 0; p < 12; p++) begin
			s_axis_tvalid <= 0;
			set_mode(modes_exp[p], modes_inv[p]);
			idle_on = ((p % 4) != 2) && (p != 3);
			if (p == 3) long_hold = 1;
			for (int i = 0; i < 125; i++)
				send_point(random_part(), random_part(), 0, none);
		end
		s_axis_tvalid <= 0;

		wait_idle();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== complex_integer_power_core.f =====
hdl/cip_pkg.sv
hdl/cip_cmul.sv
hdl/complex_integer_power_core.sv
hdl/cip_chk.sv
bench/testbench.sv
